@@ hdl/t2a_pkg.sv @@
// Package for the texel to ARGB8888 converter.
// Holds the pixel mode codes and field widths; no dependencies.
package t2a_pkg;

    localparam int TEXEL_W = 48;
    localparam int ARGB_W  = 32;
    localparam int MODE_W  = 3;
    localparam int HALF_W  = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_RGBA_SWAP = 3'd0,
        MODE_GRAY8     = 3'd1,
        MODE_RG8       = 3'd2,
        MODE_HALF_RGB  = 3'd3,
        MODE_BGRA      = 3'd4,
        MODE_RGBA8     = 3'd5,
        MODE_B5G5R5A1  = 3'd6
    } t_pixel_mode;

    localparam logic [MODE_W-1:0] PIXEL_MODE_RESET = MODE_RGBA_SWAP;

endpackage

@@ hdl/t2a_half_to_byte.sv @@
// One channel of half float to unsigned byte, round half up, clamped to [0,1].
// Depends on t2a_pkg.
module t2a_half_to_byte (
    input  logic [t2a_pkg::HALF_W-1:0] i_half,
    output logic [7:0]                 o_byte
);

    logic        sgn;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [23:0] q;       // value in Q0.24, below 1.0 when used
    logic [31:0] scaled;

    assign sgn = i_half[15];
    assign ex  = i_half[14:10];
    assign man = i_half[9:0];

    always_comb begin
        if (ex == 5'd0) begin
            q = {14'd0, man};
        end else begin
            q = {13'd0, 1'b1, man} << (ex - 5'd1);
        end
        // q*255 + 0.5, fits in 32 bits for every exponent below 15
        scaled = ({q, 8'd0} - {8'd0, q}) + 32'h0080_0000;
    end

    always_comb begin
        if (ex == 5'h1F) begin
            o_byte = (man != 10'd0 || sgn) ? 8'd0 : 8'hFF;
        end else if (sgn) begin
            o_byte = 8'd0;
        end else if (ex >= 5'd15) begin
            // 1.0 and above saturate
            o_byte = 8'hFF;
        end else begin
            o_byte = scaled[31:24];
        end
    end

endmodule

@@ hdl/t2a_format_conv.sv @@
// Combinational format conversion of one texel into a packed ARGB8888 word.
// Depends on t2a_pkg and t2a_half_to_byte.
module t2a_format_conv (
    input  logic [t2a_pkg::MODE_W-1:0]  i_mode,
    input  logic [t2a_pkg::TEXEL_W-1:0] i_texel,
    output logic [t2a_pkg::ARGB_W-1:0]  o_argb
);

    logic [7:0]  half_r;
    logic [7:0]  half_g;
    logic [7:0]  half_b;
    logic [31:0] w;

    assign w = i_texel[31:0];

    t2a_half_to_byte u_half_r (.i_half(i_texel[15:0]),  .o_byte(half_r));
    t2a_half_to_byte u_half_g (.i_half(i_texel[31:16]), .o_byte(half_g));
    t2a_half_to_byte u_half_b (.i_half(i_texel[47:32]), .o_byte(half_b));

    always_comb begin
        unique case (t2a_pkg::t_pixel_mode'(i_mode))
            t2a_pkg::MODE_RGBA_SWAP,
            t2a_pkg::MODE_RGBA8:     o_argb = {w[31:24], w[7:0], w[15:8], w[23:16]};
            t2a_pkg::MODE_GRAY8:     o_argb = {8'hFF, w[7:0], w[7:0], w[7:0]};
            t2a_pkg::MODE_RG8:       o_argb = {8'hFF, w[7:0], w[15:8], 8'd0};
            t2a_pkg::MODE_HALF_RGB:  o_argb = {8'hFF, half_r, half_g, half_b};
            t2a_pkg::MODE_BGRA:      o_argb = w;
            t2a_pkg::MODE_B5G5R5A1:  o_argb = {{8{w[15]}}, w[14:10], 3'd0,
                                               w[9:5], 3'd0, w[4:0], 3'd0};
            default:                 o_argb = '0;
        endcase
    end

endmodule

@@ hdl/texel_to_argb8888_converter.sv @@
// Top level of the texel to ARGB8888 converter: mode register, input and result registers.
// Depends on t2a_pkg and t2a_format_conv.

// Accepts one texel on every clock cycle (o_busy is always low) and returns one
// ARGB8888 word per texel, in order, through the input register and then the
// result register, with the format decode between them. o_strobe marks each
// result for exactly one cycle; the receiver cannot stall.
// Write i_pixel_mode only while no transaction is in flight.
module texel_to_argb8888_converter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_pixel_mode_we,
    input  logic [t2a_pkg::MODE_W-1:0]  i_pixel_mode_wdata,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [t2a_pkg::TEXEL_W-1:0] i_raw_texel,
    output logic                        o_strobe,
    output logic [t2a_pkg::ARGB_W-1:0]  o_argb_word
);

    logic [t2a_pkg::MODE_W-1:0]  r_mode;
    logic                        r_in_valid;
    logic [t2a_pkg::TEXEL_W-1:0] r_in_texel;
    logic [t2a_pkg::MODE_W-1:0]  r_in_mode;
    logic                        r_out_valid;
    logic [t2a_pkg::ARGB_W-1:0]  r_out_argb;
    logic [t2a_pkg::ARGB_W-1:0]  n_out_argb;

    assign o_busy = 1'b0;

    t2a_format_conv u_conv (
        .i_mode  (r_in_mode),
        .i_texel (r_in_texel),
        .o_argb  (n_out_argb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= t2a_pkg::PIXEL_MODE_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pixel_mode_we) begin
                r_mode <= i_pixel_mode_wdata;
            end
            r_in_valid  <= i_start && !o_busy;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_texel <= i_raw_texel;
        r_in_mode  <= r_mode;
        r_out_argb <= n_out_argb;
    end

    assign o_strobe    = r_out_valid;
    assign o_argb_word = r_out_argb;

    a_strobe_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_start, 2))
        else $error("result strobe without a start two cycles earlier");

    a_start_gives_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_in_valid) |=> (r_in_valid && o_strobe))
        else $error("back-to-back transactions lost a result");

    a_half_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_mode == t2a_pkg::MODE_HALF_RGB) |=> (o_argb_word[31:24] == 8'hFF))
        else $error("half float result is not opaque");

endmodule
